@@ src/alu_8bit_with_flags_unit_macros.svh @@
// ---------------------------------------------------------------------------
// alu_8bit_with_flags_unit_macros.svh
// Assertion macros shared by the ALU checker.
// ---------------------------------------------------------------------------
`ifndef ALU_8BIT_WITH_FLAGS_UNIT_MACROS_SVH
`define ALU_8BIT_WITH_FLAGS_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ALU8F_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define ALU8F_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/alu8f_pkg.sv @@
// ---------------------------------------------------------------------------
// alu8f_pkg
// Operation codes and word types of the 8-bit ALU.
// ---------------------------------------------------------------------------
package alu8f_pkg;

    localparam int DATA_W = 8;
    localparam int CMD_W  = 5;
    localparam int CNT_W  = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD  = 5'd0,
        CMD_SUB  = 5'd1,
        CMD_INC  = 5'd2,
        CMD_DEC  = 5'd3,
        CMD_NEG  = 5'd4,
        CMD_CMP  = 5'd5,
        CMD_AND  = 5'd6,
        CMD_OR   = 5'd7,
        CMD_XOR  = 5'd8,
        CMD_NOT  = 5'd9,
        CMD_TEST = 5'd10,
        CMD_SHL  = 5'd11,
        CMD_SHR  = 5'd12,
        CMD_SAL  = 5'd13,
        CMD_SAR  = 5'd14,
        CMD_ROL  = 5'd15,
        CMD_ROR  = 5'd16,
        CMD_RCL  = 5'd17,
        CMD_RCR  = 5'd18
    } cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] operand_a;
        logic [DATA_W-1:0] operand_b;
        logic              signed_mode;
        logic [CNT_W-1:0]  shift_count;
    } op_t;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              writes_result;
        logic              flag_carry;
        logic              flag_overflow;
        logic              flag_negative;
        logic              flag_zero;
    } res_t;

endpackage

@@ src/alu_8bit_with_flags_unit.sv @@
// ---------------------------------------------------------------------------
// alu_8bit_with_flags_unit
// 8-bit ALU with N, Z, C, V flags; registered in, registered out.
// ---------------------------------------------------------------------------
//  channel | valid     | stall     | word
//  --------+-----------+-----------+--------------------------------
//  op      | op_valid  | op_stall  | op  (cmd, operands, mode, count)
//  res     | res_valid | res_stall | res (result byte and flags)
//
//  One word per cycle sustained while res is not stalled; the operand
//  register feeds the ALU and barrel shifter, then the result register.
//  Reset clears both stage valids; no state beyond that.
//  A stall on res backs up through the result register into the operand
//  register; op_stall rises only when both stages hold a word and res is
//  stalled.
// ---------------------------------------------------------------------------
module alu_8bit_with_flags_unit
    import alu8f_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic op_valid,
    output logic op_stall,
    input  op_t  op,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    // pipeline control
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    op_t  s1_op_reg;
    res_t s2_res_reg;
    logic s1_ready;
    logic s2_ready;
    logic s1_load;
    logic s2_load;

    assign s2_ready = !s2_valid_reg || !res_stall;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign op_stall = !s1_ready;
    assign s1_load  = op_valid && s1_ready;
    assign s2_load  = s1_valid_reg && s2_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_ready)
        begin
            s1_valid_next = op_valid;
        end
        s2_valid_next = s2_valid_reg;
        if (s2_ready)
        begin
            s2_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // ---------------------------------------------------------------------
    // Datapath: adder/subtractor, logic ops and closed-form shifters
    // ---------------------------------------------------------------------
    logic [DATA_W-1:0]     a;
    logic [DATA_W-1:0]     b;
    logic [CNT_W-1:0]      cnt;
    logic [DATA_W:0]       sum9;
    logic [DATA_W:0]       diff9;
    logic [3*DATA_W-1:0]   shl_w;
    logic [2*DATA_W-1:0]   shr_w;
    logic signed [2*DATA_W-1:0] sar_w;
    logic [2*DATA_W-1:0]   rol_w;
    logic [2*DATA_W-1:0]   ror_w;
    logic [CNT_W-1:0]      rc_k;
    logic [2*DATA_W+1:0]   rcl_w;
    logic [2*DATA_W+1:0]   rcr_w;
    logic [DATA_W-1:0]     r;
    logic                  c;
    logic                  v;
    logic                  wr;
    logic                  ok;
    logic                  cnt_zero;
    res_t                  res_next;

    assign a        = s1_op_reg.operand_a;
    assign b        = s1_op_reg.operand_b;
    assign cnt      = s1_op_reg.shift_count;
    assign cnt_zero = (cnt == '0);

    assign sum9  = {1'b0, a} + {1'b0, b};
    assign diff9 = {1'b0, a} - {1'b0, b};    // bit 8 is the borrow

    // left shifts: bit just above the byte is the last bit moved out; right shifts: the bit just below it
    assign shl_w = {{(2*DATA_W){1'b0}}, a} << cnt;
    assign shr_w = {a, {DATA_W{1'b0}}} >> cnt;
    assign sar_w = $signed({a, {DATA_W{1'b0}}}) >>> cnt;
    assign rol_w = {a, a} << cnt[2:0];
    assign ror_w = {a, a} >> cnt[2:0];

    // rotate through carry is a 9-bit rotate of {carry=0, a}
    assign rc_k  = (cnt >= 4'd9) ? (cnt - 4'd9) : cnt;
    assign rcl_w = {1'b0, a, 1'b0, a} << rc_k;
    assign rcr_w = {1'b0, a, 1'b0, a} >> rc_k;

    always_comb
    begin
        r  = '0;
        c  = 1'b0;
        v  = 1'b0;
        wr = 1'b1;
        ok = 1'b1;
        case (cmd_t'(s1_op_reg.cmd))
            CMD_ADD:
            begin
                r = sum9[DATA_W-1:0];
                c = sum9[DATA_W];
                v = (a[7] == b[7]) && (r[7] != a[7]);
            end
            CMD_SUB, CMD_CMP:
            begin
                r = diff9[DATA_W-1:0];
                c = diff9[DATA_W];
                v = (a[7] != b[7]) && (r[7] != a[7]);
            end
            CMD_INC:
            begin
                r = a + 8'd1;
                c = (a == 8'hFF);
                v = (a == 8'h7F);
            end
            CMD_DEC:
            begin
                r = a - 8'd1;
                c = (a == 8'h00);
                v = (a == 8'h80);
            end
            CMD_NEG:
            begin
                r = 8'd0 - a;
                c = (a != 8'h00);
                v = (a == 8'h80);
            end
            CMD_AND, CMD_TEST: r = a & b;
            CMD_OR:            r = a | b;
            CMD_XOR:           r = a ^ b;
            CMD_NOT:           r = ~a;
            CMD_SHL, CMD_SAL:
            begin
                r = shl_w[DATA_W-1:0];
                c = shl_w[DATA_W];
            end
            CMD_SHR:
            begin
                r = shr_w[2*DATA_W-1:DATA_W];
                c = shr_w[DATA_W-1];
            end
            CMD_SAR:
            begin
                r = sar_w[2*DATA_W-1:DATA_W];
                c = sar_w[DATA_W-1];
            end
            CMD_ROL:
            begin
                r = rol_w[2*DATA_W-1:DATA_W];
                c = rol_w[DATA_W];
            end
            CMD_ROR:
            begin
                r = ror_w[DATA_W-1:0];
                c = ror_w[DATA_W-1];
            end
            CMD_RCL:
            begin
                r = rcl_w[2*DATA_W:DATA_W+1];
                c = rcl_w[2*DATA_W+1];
            end
            CMD_RCR:
            begin
                r = rcr_w[DATA_W-1:0];
                c = rcr_w[DATA_W];
            end
            default:
            begin
                ok = 1'b0;
                wr = 1'b0;
            end
        endcase

        // zero count: operand unchanged, carry clear
        if (s1_op_reg.cmd >= CMD_SHL && s1_op_reg.cmd <= CMD_RCR && cnt_zero)
        begin
            r = a;
            c = 1'b0;
        end
        if (cmd_t'(s1_op_reg.cmd) == CMD_SAL && !cnt_zero)
        begin
            v = (r[7] != a[7]);
        end
        if (!s1_op_reg.signed_mode)
        begin
            v = 1'b0;
        end

        // N and Z follow the computed value even when it is not written (compare, test); undefined codes clear them
        res_next.flag_carry    = c;
        res_next.flag_overflow = v;
        res_next.flag_negative = ok && r[7];
        res_next.flag_zero     = ok && (r == '0);
        if (cmd_t'(s1_op_reg.cmd) == CMD_CMP || cmd_t'(s1_op_reg.cmd) == CMD_TEST)
        begin
            wr = 1'b0;
        end
        res_next.writes_result = wr;
        res_next.result        = wr ? r : '0;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_op_reg <= op;
        end
        if (s2_load)
        begin
            s2_res_reg <= res_next;
        end
    end

    assign res_valid = s2_valid_reg;
    assign res       = s2_res_reg;

endmodule

@@ src/alu8f_checker.sv @@
// ---------------------------------------------------------------------------
// alu8f_checker
// Port-level checks on the ALU result channel, bound to alu_8bit_with_flags_unit.
// ---------------------------------------------------------------------------
`include "alu_8bit_with_flags_unit_macros.svh"

module alu8f_checker
    import alu8f_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic res_valid,
    input logic res_stall,
    input res_t res
);

    `ALU8F_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && res_stall, res_valid, "res_valid dropped while stalled")
    `ALU8F_ASSERT_NEXT(a_res_stable, clk, rst_n, res_valid && res_stall, $stable(res), "res word changed while stalled")
    `ALU8F_ASSERT_SAME(a_no_write_zero, clk, rst_n, res_valid && !res.writes_result, res.result == '0, "flag-only word carries a result")
    `ALU8F_ASSERT_SAME(a_zero_flag, clk, rst_n, res_valid && res.writes_result, res.flag_zero == (res.result == '0), "Z disagrees with result")

endmodule

bind alu_8bit_with_flags_unit alu8f_checker u_alu8f_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

@@ test/tb_alu_8bit_with_flags_unit.sv @@
// ---------------------------------------------------------------------------
// tb_alu_8bit_with_flags_unit
// Self-checking bench for the 8-bit ALU with N, Z, C and V flags. Operation
// words are driven with random gaps and result words are taken under random
// stalls. Each accepted operation word is turned into its expected result
// word by an in-bench ALU model. Every result word is checked field by field
// against the oldest expected word still outstanding.
// ---------------------------------------------------------------------------
module tb_alu_8bit_with_flags_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import alu8f_pkg::*;

    // codes past the last defined operation; the ALU must return all zeros
    localparam logic [CMD_W-1:0] CMD_UNDEF_FIRST = 5'd19;
    localparam logic [CMD_W-1:0] CMD_UNDEF_LAST  = 5'd31;

    localparam int RANDOM_WORDS = 700;
    localparam int CALM_WORDS   = 100;   // tail of the run without gaps or stalls

    logic clk;
    logic rst_n;
    logic op_valid;
    logic op_stall;
    op_t  op;
    logic res_valid;
    logic res_stall;
    res_t res;

    bit   idling;        // enables gaps on op and stalls on res
    int   stall_left;

    // -----------------------------------------------------------------------
    // Scoreboard: holds the expected result words in order of issue.
    // -----------------------------------------------------------------------
    class alu_scoreboard;
        typedef struct {
            op_t  word;
            res_t outcome;
        } pending_t;

        pending_t pending_q[$];
        int       mismatches;

        // Expected result word for one operation word.
        function res_t alu_outcome(op_t w);
            logic [DATA_W:0]   wide;
            logic [DATA_W-1:0] a;
            logic [DATA_W-1:0] b;
            logic [DATA_W-1:0] r;
            logic [DATA_W-1:0] nz_src;
            logic              c;
            logic              v;
            logic              wr;
            logic              known;
            logic              hi;
            logic              lo;
            res_t              o;
            int                i;

            a     = w.operand_a;
            b     = w.operand_b;
            r     = '0;
            c     = 1'b0;
            v     = 1'b0;
            wr    = 1'b1;
            known = 1'b1;

            case (w.cmd)
                CMD_ADD:
                begin
                    wide = {1'b0, a} + {1'b0, b};
                    r    = wide[DATA_W-1:0];
                    c    = wide[DATA_W];
                    v    = (a[7] == b[7]) && (r[7] != a[7]);
                end
                CMD_SUB, CMD_CMP:
                begin
                    r = a - b;
                    c = a < b;
                    v = (a[7] != b[7]) && (r[7] != a[7]);
                end
                CMD_INC:
                begin
                    r = a + 8'd1;
                    c = (a == 8'hFF);
                    v = (a == 8'h7F);
                end
                CMD_DEC:
                begin
                    r = a - 8'd1;
                    c = (a == 8'h00);
                    v = (a == 8'h80);
                end
                CMD_NEG:
                begin
                    r = 8'd0 - a;
                    c = (a != 8'h00);
                    v = (r == 8'h80);
                end
                CMD_AND, CMD_TEST: r = a & b;
                CMD_OR:            r = a | b;
                CMD_XOR:           r = a ^ b;
                CMD_NOT:           r = ~a;
                CMD_SHL, CMD_SHR, CMD_SAL, CMD_SAR,
                CMD_ROL, CMD_ROR, CMD_RCL, CMD_RCR:
                begin
                    // one bit per step, so long counts fall out naturally
                    r = a;
                    for (i = 0; i < int'(w.shift_count); i++)
                    begin
                        hi = r[7];
                        lo = r[0];
                        case (w.cmd)
                            CMD_SHL, CMD_SAL:
                            begin
                                c = hi;
                                r = {r[6:0], 1'b0};
                            end
                            CMD_SHR:
                            begin
                                c = lo;
                                r = {1'b0, r[7:1]};
                            end
                            CMD_SAR:
                            begin
                                c = lo;
                                r = {hi, r[7:1]};
                            end
                            CMD_ROL:
                            begin
                                c = hi;
                                r = {r[6:0], hi};
                            end
                            CMD_ROR:
                            begin
                                c = lo;
                                r = {lo, r[7:1]};
                            end
                            CMD_RCL:
                            begin
                                r = {r[6:0], c};
                                c = hi;
                            end
                            default:
                            begin
                                r = {c, r[7:1]};
                                c = lo;
                            end
                        endcase
                    end
                    if (w.cmd == CMD_SAL && w.shift_count != '0)
                        v = (r[7] != a[7]);
                end
                default: known = 1'b0;
            endcase

            if (!w.signed_mode)
                v = 1'b0;
            nz_src = r;
            // compare and test only set flags; undefined codes write no result
            if (w.cmd == CMD_CMP || w.cmd == CMD_TEST || !known)
            begin
                wr = 1'b0;
                r  = '0;
            end

            o.result        = r;
            o.writes_result = wr;
            o.flag_carry    = known & c;
            o.flag_overflow = known & v;
            o.flag_negative = known & nz_src[7];
            o.flag_zero     = known & (nz_src == '0);
            return o;
        endfunction

        function void note_op(op_t w);
            pending_t p;
            p.word    = w;
            p.outcome = alu_outcome(w);
            pending_q.push_back(p);
        endfunction

        function void check_res(res_t got);
            pending_t p;
            logic     bad;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result word with nothing outstanding: %p", $realtime, got);
                return;
            end
            p   = pending_q.pop_front();
            bad = (got.result        !== p.outcome.result)        ||
                  (got.writes_result !== p.outcome.writes_result) ||
                  (got.flag_carry    !== p.outcome.flag_carry)    ||
                  (got.flag_overflow !== p.outcome.flag_overflow) ||
                  (got.flag_negative !== p.outcome.flag_negative) ||
                  (got.flag_zero     !== p.outcome.flag_zero);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: op %p\n    expected %p\n    actual   %p",
                             $realtime, p.word, p.outcome, got);
            end
        endfunction
    endclass

    alu_scoreboard sb;

    alu_8bit_with_flags_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_stall  (op_stall),
        .op        (op),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // 12 ns period
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // -----------------------------------------------------------------------
    // Result side. Handshake signals are read straight after the edge, so
    // they hold the values from before it; res_stall comes in bursts and is
    // owned by this block alone.
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            sb.check_res(res);

        if (stall_left != 0)
        begin
            stall_left--;
            res_stall <= 1'b1;
        end
        else if (idling && rst_n && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(0, 3);
            res_stall <= 1'b1;
        end
        else
        begin
            res_stall <= 1'b0;
        end
    end

    // Drive one operation word and wait for it to be taken. An optional gap
    // with valid low goes before it; valid is never tied to op_stall.
    task automatic issue_op(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] a,
                            logic [DATA_W-1:0] b, logic sm, logic [CNT_W-1:0] cnt);
        op_t w;
        w = '{cmd: cmd, operand_a: a, operand_b: b, signed_mode: sm, shift_count: cnt};
        if (idling && $urandom_range(0, 3) == 0)
        begin
            op_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        op_valid <= 1'b1;
        op       <= w;
        @(posedge clk);
        while (op_stall)
            @(posedge clk);
        sb.note_op(w);
    endtask

    // operands lean towards the sign and carry boundaries
    function automatic logic [DATA_W-1:0] pick_operand();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'h7F;
            2:       return 8'h80;
            3:       return 8'hFF;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [CMD_W-1:0] cmd;
        int               n;

        sb          = new();
        idling      = 1'b0;
        rst_n       = 1'b0;
        op_valid   <= 1'b0;
        op         <= '0;
        repeat (11) @(posedge clk);
        rst_n      <= 1'b1;
        @(posedge clk);

        // --- directed: edges of each operation ---
        issue_op(CMD_ADD,  8'hFF, 8'h01, 1'b1, 4'd0);   // carry out, zero result
        issue_op(CMD_ADD,  8'h7F, 8'h01, 1'b1, 4'd3);   // signed overflow
        issue_op(CMD_SUB,  8'h00, 8'h01, 1'b1, 4'd0);   // borrow
        issue_op(CMD_SUB,  8'h80, 8'h01, 1'b1, 4'd0);   // signed overflow
        issue_op(CMD_INC,  8'hFF, 8'h00, 1'b0, 4'd0);
        issue_op(CMD_INC,  8'h7F, 8'h00, 1'b1, 4'd0);
        issue_op(CMD_DEC,  8'h00, 8'h00, 1'b1, 4'd0);
        issue_op(CMD_DEC,  8'h80, 8'hFF, 1'b1, 4'd0);
        issue_op(CMD_NEG,  8'h00, 8'h00, 1'b1, 4'd0);
        issue_op(CMD_NEG,  8'h80, 8'h00, 1'b1, 4'd0);   // result 0x80 flags V
        issue_op(CMD_CMP,  8'h7F, 8'h80, 1'b1, 4'd0);   // flags only
        issue_op(CMD_AND,  8'hF0, 8'h0F, 1'b0, 4'd0);
        issue_op(CMD_OR,   8'hFF, 8'h00, 1'b1, 4'd0);
        issue_op(CMD_XOR,  8'hAA, 8'h55, 1'b1, 4'd0);
        issue_op(CMD_NOT,  8'hFF, 8'h00, 1'b1, 4'd0);
        issue_op(CMD_TEST, 8'hAA, 8'h55, 1'b1, 4'd0);   // flags only, zero
        issue_op(CMD_SHL,  8'h81, 8'h00, 1'b1, 4'd1);
        issue_op(CMD_SHR,  8'h81, 8'h00, 1'b1, 4'd0);   // zero count
        issue_op(CMD_SAL,  8'h40, 8'h00, 1'b1, 4'd1);   // sign changes
        issue_op(CMD_SAR,  8'h80, 8'h00, 1'b1, 4'd15);  // long count, all sign bits
        issue_op(CMD_ROL,  8'h81, 8'h00, 1'b0, 4'd9);
        issue_op(CMD_ROR,  8'h01, 8'h00, 1'b1, 4'd8);
        issue_op(CMD_RCL,  8'h80, 8'h00, 1'b1, 4'd1);
        issue_op(CMD_RCR,  8'h01, 8'hFF, 1'b1, 4'd15);
        issue_op(CMD_UNDEF_LAST, 8'hFF, 8'hFF, 1'b1, 4'd15);

        // --- random: mostly defined codes, some undefined ones ---
        idling = 1'b1;
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == RANDOM_WORDS - CALM_WORDS)
                idling = 1'b0;
            if ($urandom_range(0, 9) == 0)
                cmd = CMD_W'($urandom_range(CMD_UNDEF_FIRST, CMD_UNDEF_LAST));
            else
                cmd = CMD_W'($urandom_range(CMD_ADD, CMD_RCR));
            issue_op(cmd, pick_operand(), pick_operand(), 1'($urandom),
                     CNT_W'($urandom));
        end
        op_valid <= 1'b0;

        // drain, then allow the two-stage pipe to settle
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/alu8f_pkg.sv
src/alu_8bit_with_flags_unit.sv
src/alu8f_checker.sv
test/tb_alu_8bit_with_flags_unit.sv
